[rtl/mbeb_pkg.sv]
package mbeb_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_REGS = 8;

  localparam logic [3:0] REG_PIXEL_BITS   = 4'd0;
  localparam logic [3:0] REG_FORE_COLOR   = 4'd1;
  localparam logic [3:0] REG_BACK_COLOR   = 4'd2;
  localparam logic [3:0] REG_ROW_WIDTH    = 4'd3;
  localparam logic [3:0] REG_ROW_COUNT    = 4'd4;
  localparam logic [3:0] REG_START_OFFSET = 4'd5;
  localparam logic [3:0] REG_PITCH_REM    = 4'd6;
  localparam logic [3:0] REG_SWAPPED      = 4'd7;

  localparam logic [5:0]  RST_PIXEL_BITS   = 6'd8;
  localparam logic [31:0] RST_FORE_COLOR   = 32'hffff_ffff;
  localparam logic [31:0] RST_BACK_COLOR   = 32'h0000_0000;
  localparam logic [12:0] RST_ROW_WIDTH    = 13'd8;
  localparam logic [12:0] RST_ROW_COUNT    = 13'd16;
  localparam logic [4:0]  RST_START_OFFSET = 5'd0;
  localparam logic [4:0]  RST_PITCH_REM    = 5'd0;
  localparam logic        RST_SWAPPED      = 1'b0;

  typedef struct packed {
    logic [5:0]  pixel_bits;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic [12:0] row_width;
    logic [12:0] row_count;
    logic [4:0]  start_offset;
    logic [4:0]  pitch_rem;
    logic        swapped;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bits;
    logic [2:0] last_pix;
    logic       row_end;
    logic       image_end;
  } job_t;

  function automatic logic bpp_ok(input logic [5:0] bpp);
    return bpp inside {6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32};
  endfunction

  function automatic logic [2:0] bpp_lg(input logic [5:0] bpp);
    logic [2:0] lg;
    case (bpp)
      6'd1:    lg = 3'd0;
      6'd2:    lg = 3'd1;
      6'd4:    lg = 3'd2;
      6'd8:    lg = 3'd3;
      6'd16:   lg = 3'd4;
      6'd32:   lg = 3'd5;
      default: lg = 3'd0;
    endcase
    return lg;
  endfunction

  function automatic logic [31:0] span_mask(input logic [4:0] lo, input logic [5:0] hi,
                                            input logic swap);
    logic [31:0] m;
    logic [31:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (6'(i) >= {1'b0, lo}) && (6'(i) < hi);
    end
    for (int i = 0; i < WORD_W; i++) begin
      r[WORD_W - 1 - i] = m[i];
    end
    return swap ? r : m;
  endfunction

endpackage

[rtl/mbeb_front.sv]
module mbeb_front #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int CNT_W          = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rearm,
  input  mbeb_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_bitmap_byte,
  input  logic               q_full,
  output logic               q_push,
  output mbeb_pkg::job_t     q_job
);
  import mbeb_pkg::*;

  logic [CNT_W-1:0] pir_r, pir_nxt;
  logic [12:0]      row_r, row_nxt;
  logic [CNT_W-1:0] rw_c, max_c, eff, remaining;
  logic [12:0]      rows;
  logic             row_end, last_row, accept;

  always_comb begin
    rw_c      = CNT_W'(cfg.row_width);
    max_c     = CNT_W'(MAX_ROW_PIXELS);
    eff       = (rw_c == '0) ? CNT_W'(1) : ((rw_c > max_c) ? max_c : rw_c);
    remaining = eff - pir_r;
    row_end   = remaining <= CNT_W'(8);
    rows      = (cfg.row_count == 13'd0) ? 13'd1 : cfg.row_count;
    last_row  = ({1'b0, row_r} + 14'd1) >= {1'b0, rows};
    accept    = in_valid && !q_full && !rearm;
    q_push    = accept && bpp_ok(cfg.pixel_bits);

    q_job.bits      = in_bitmap_byte;
    q_job.last_pix  = row_end ? 3'(remaining - CNT_W'(1)) : 3'd7;
    q_job.row_end   = row_end;
    q_job.image_end = row_end && last_row;

    pir_nxt = pir_r;
    row_nxt = row_r;
    if (q_push) begin
      if (row_end) begin
        pir_nxt = '0;
        row_nxt = last_row ? 13'd0 : row_r + 13'd1;
      end else begin
        pir_nxt = pir_r + CNT_W'(8);
      end
    end
  end

  assign in_stall = q_full || rearm;

  always_ff @(posedge clk) begin
    if (!rst_n || rearm) begin
      pir_r <= '0;
      row_r <= '0;
    end else begin
      pir_r <= pir_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/mbeb_queue.sv]
module mbeb_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  logic           push,
  input  mbeb_pkg::job_t din,
  input  logic           pop,
  output mbeb_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import mbeb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign head  = slot_r[rd_r];
  assign empty = cnt_r == '0;
  assign full  = cnt_r == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/mbeb_back.sv]
module mbeb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rearm,
  input  mbeb_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  mbeb_pkg::job_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_word_value,
  output logic [31:0]    out_word_mask,
  output logic           out_row_end,
  output logic           out_image_end,
  output logic           out_last_of_run
);
  import mbeb_pkg::*;

  logic [2:0]  pix_r, pix_nxt;
  logic        tail_r, tail_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        first_r, first_nxt;
  logic [4:0]  roff_r, roff_nxt;

  logic        out_valid_r;
  logic [31:0] val_r, mask_r;
  logic        row_end_r, image_end_r, last_r;

  logic [2:0]  lg;
  logic [31:0] cmask, color, word, mask, acc_emit;
  logic [63:0] a64, shifted;
  logic [6:0]  swap_amt;
  logic [5:0]  f;
  logic [4:0]  f2, lo_bit, new_roff;
  logic [2:0]  rem;
  logic [7:0]  s;
  logic        emit, last_pix, byte_last, out_free, step, produce;
  logic        p_row_end, p_image_end, p_last;

  always_comb begin
    lg = bpp_lg(cfg.pixel_bits);
    for (int i = 0; i < WORD_W; i++) begin
      cmask[i] = 6'(i) < cfg.pixel_bits;
    end
    color    = (q_head.bits[3'd7 - pix_r] ? cfg.fore_color : cfg.back_color) & cmask;
    swap_amt = 7'd64 - {2'b00, fill_r} - {1'b0, cfg.pixel_bits};
    if (cfg.swapped) begin
      shifted = {32'd0, color} << swap_amt[5:0];
      a64     = {acc_r, 32'd0} | shifted;
    end else begin
      shifted = {32'd0, color} << fill_r;
      a64     = {32'd0, acc_r} | shifted;
    end
    f     = {1'b0, fill_r} + cfg.pixel_bits;
    emit  = f[5];
    f2    = f[4:0];
    if (cfg.swapped) begin
      acc_emit = emit ? a64[31:0] : a64[63:32];
    end else begin
      acc_emit = emit ? a64[63:32] : a64[31:0];
    end
    last_pix  = pix_r == q_head.last_pix;
    rem       = q_head.last_pix - pix_r;
    s         = {3'd0, f2} + (8'(rem) << lg);
    byte_last = (s < 8'd32) && !(q_head.row_end && (s != 8'd0));
    lo_bit    = first_r ? roff_r : 5'd0;
    new_roff  = q_head.image_end ? cfg.start_offset : roff_r + cfg.pitch_rem;
    out_free  = !out_valid_r || !out_stall;
    step      = !q_empty && out_free;

    if (tail_r) begin
      produce     = 1'b1;
      word        = acc_r;
      mask        = span_mask(lo_bit, {1'b0, fill_r}, cfg.swapped);
      p_row_end   = 1'b1;
      p_image_end = q_head.image_end;
      p_last      = 1'b1;
    end else begin
      produce     = emit;
      word        = cfg.swapped ? a64[63:32] : a64[31:0];
      mask        = span_mask(lo_bit, 6'd32, cfg.swapped);
      p_row_end   = q_head.row_end && byte_last;
      p_image_end = q_head.image_end && q_head.row_end && byte_last;
      p_last      = byte_last;
    end

    pix_nxt   = pix_r;
    tail_nxt  = tail_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    first_nxt = first_r;
    roff_nxt  = roff_r;
    q_pop     = 1'b0;
    if (step) begin
      if (tail_r) begin
        tail_nxt  = 1'b0;
        pix_nxt   = 3'd0;
        acc_nxt   = '0;
        fill_nxt  = new_roff;
        roff_nxt  = new_roff;
        first_nxt = 1'b1;
        q_pop     = 1'b1;
      end else begin
        acc_nxt   = acc_emit;
        fill_nxt  = f2;
        first_nxt = first_r && !emit;
        if (!last_pix) begin
          pix_nxt = pix_r + 3'd1;
        end else if (q_head.row_end && (f2 != 5'd0)) begin
          tail_nxt = 1'b1;
        end else if (q_head.row_end) begin
          pix_nxt   = 3'd0;
          acc_nxt   = '0;
          fill_nxt  = new_roff;
          roff_nxt  = new_roff;
          first_nxt = 1'b1;
          q_pop     = 1'b1;
        end else begin
          pix_nxt = 3'd0;
          q_pop   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r   <= '0;
      tail_r  <= 1'b0;
      acc_r   <= '0;
      fill_r  <= RST_START_OFFSET;
      first_r <= 1'b1;
      roff_r  <= RST_START_OFFSET;
    end else if (rearm) begin
      pix_r   <= '0;
      tail_r  <= 1'b0;
      acc_r   <= '0;
      fill_r  <= cfg.start_offset;
      first_r <= 1'b1;
      roff_r  <= cfg.start_offset;
    end else begin
      pix_r   <= pix_nxt;
      tail_r  <= tail_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
      roff_r  <= roff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rearm) begin
      out_valid_r <= 1'b0;
    end else if (step && produce) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      val_r       <= word & mask;
      mask_r      <= mask;
      row_end_r   <= p_row_end;
      image_end_r <= p_image_end;
      last_r      <= p_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_value  = val_r;
  assign out_word_mask   = mask_r;
  assign out_row_end     = row_end_r;
  assign out_image_end   = image_end_r;
  assign out_last_of_run = last_r;

endmodule

[rtl/mono_bitmap_expand_blit.sv]
// Monochrome bitmap color-expansion blitter.
// Input channel (in_valid / in_stall / in_bitmap_byte): one source byte per
// request, bit 7 first, bitmap rows padded to whole bytes.
// Output channel (out_valid / out_stall / out_*): one 32-bit framebuffer
// word per request with its write mask and row, image and byte-end marks.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// always ready; any write to a defined register restarts the image.
// The front end sorts each byte into a pixel count and row marks and puts it
// into a small queue; the packer behind it places one pixel per cycle while
// the queue holds a byte and the output is free, only the pixels of the byte
// inside the row (8 in mid-row), and an extra step sends a partial word at
// the end of a row; later bytes wait in the queue meanwhile. A full word shows
// the cycle after the packer places the pixel that completes it; with the
// queue empty and the output free, the first pixel of a byte is placed the
// cycle after its request. The input stalls while the queue is full and for
// the cycle after a write to a defined register. A stalled output holds its
// word; the packer waits, then the queue fills, then the input stalls.
// Reset loads the register defaults and starts a new image. Bytes taken
// while pixel_bits is not a supported depth are dropped.
module mono_bitmap_expand_blit #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_bitmap_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word_value,
  output logic [31:0] out_word_mask,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mbeb_pkg::*;

  localparam int PIX_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CNT_W = (PIX_W > 13) ? PIX_W : 13;

  cfg_t cfg_r;
  logic rearm_r;
  logic q_push, q_pop, q_empty, q_full;
  job_t q_job, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bits   <= RST_PIXEL_BITS;
      cfg_r.fore_color   <= RST_FORE_COLOR;
      cfg_r.back_color   <= RST_BACK_COLOR;
      cfg_r.row_width    <= RST_ROW_WIDTH;
      cfg_r.row_count    <= RST_ROW_COUNT;
      cfg_r.start_offset <= RST_START_OFFSET;
      cfg_r.pitch_rem    <= RST_PITCH_REM;
      cfg_r.swapped      <= RST_SWAPPED;
      rearm_r            <= 1'b0;
    end else begin
      rearm_r <= cfg_valid && cfg_ready && (cfg_index < 4'(NUM_REGS));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PIXEL_BITS:   cfg_r.pixel_bits   <= cfg_data[5:0];
          REG_FORE_COLOR:   cfg_r.fore_color   <= cfg_data;
          REG_BACK_COLOR:   cfg_r.back_color   <= cfg_data;
          REG_ROW_WIDTH:    cfg_r.row_width    <= cfg_data[12:0];
          REG_ROW_COUNT:    cfg_r.row_count    <= cfg_data[12:0];
          REG_START_OFFSET: cfg_r.start_offset <= cfg_data[4:0];
          REG_PITCH_REM:    cfg_r.pitch_rem    <= cfg_data[4:0];
          REG_SWAPPED:      cfg_r.swapped      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  mbeb_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .CNT_W         (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .rearm         (rearm_r),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bitmap_byte(in_bitmap_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  mbeb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (rearm_r),
    .push (q_push),
    .din  (q_job),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty),
    .full (q_full)
  );

  mbeb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rearm          (rearm_r),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_value (out_word_value),
    .out_word_mask  (out_word_mask),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .out_last_of_run(out_last_of_run)
  );

endmodule

[rtl/mbeb_check.sv]
module mbeb_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_word_value,
  input logic [31:0] out_word_mask,
  input logic        out_row_end,
  input logic        out_image_end,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_value) && $stable(out_word_mask))
    else $error("stalled output word changed");

  a_value_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_value & ~out_word_mask) == 32'd0)
    else $error("word value has bits outside its mask");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_mask != 32'd0)
    else $error("word emitted with empty mask");

  a_image_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  a_row_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_last_of_run)
    else $error("row end not on last word of a byte");

endmodule

bind mono_bitmap_expand_blit mbeb_check u_mbeb_check (.*);

[tb/sv/tb_mono_bitmap_expand_blit.sv]
module tb_mono_bitmap_expand_blit;
  import mbeb_pkg::*;

  localparam int MAX_PIX      = 4096;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_BYTES = 300;
  localparam logic [3:0] REG_LAST_CODE = 4'hf;

  typedef struct {
    bit [31:0] value;
    bit [31:0] mask;
    bit        row_end;
    bit        image_end;
    bit        last_of_run;
  } word_t;

  typedef struct {
    bit [5:0]  bpp;
    bit [31:0] fg;
    bit [31:0] bg;
    bit [12:0] width;
    bit [12:0] rows;
    bit [4:0]  start;
    bit [4:0]  pitch;
    bit        swap;
  } setup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_bitmap_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [3:0]  cfg_index = 4'h0;
  logic [31:0] cfg_data = 32'h0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_word_value;
  logic [31:0] out_word_mask;
  logic        out_row_end;
  logic        out_image_end;
  logic        out_last_of_run;
  logic        cfg_ready;

  mono_bitmap_expand_blit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_bitmap_byte  (in_bitmap_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_value  (out_word_value),
    .out_word_mask   (out_word_mask),
    .out_row_end     (out_row_end),
    .out_image_end   (out_image_end),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  class blit_scoreboard;
    bit [5:0]  bpp;
    bit [31:0] fg;
    bit [31:0] bg;
    bit [12:0] width_reg;
    bit [12:0] rows_reg;
    bit [4:0]  start_off;
    bit [4:0]  pitch;
    bit        swap;
    bit [31:0] acc;
    int        fill;
    int        pix;
    int        row;
    bit [4:0]  row_off;
    bit        first;
    word_t     pending[$];
    int        errors;

    function new();
      bpp       = RST_PIXEL_BITS;
      fg        = RST_FORE_COLOR;
      bg        = RST_BACK_COLOR;
      width_reg = RST_ROW_WIDTH;
      rows_reg  = RST_ROW_COUNT;
      start_off = RST_START_OFFSET;
      pitch     = RST_PITCH_REM;
      swap      = RST_SWAPPED;
      errors    = 0;
      rearm();
    endfunction

    function void rearm();
      acc     = 32'h0;
      fill    = start_off;
      row_off = start_off;
      pix     = 0;
      row     = 0;
      first   = 1'b1;
    endfunction

    function bit depth_ok();
      return bpp inside {6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32};
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] data);
      case (idx)
        REG_PIXEL_BITS:   bpp = data[5:0];
        REG_FORE_COLOR:   fg = data;
        REG_BACK_COLOR:   bg = data;
        REG_ROW_WIDTH:    width_reg = data[12:0];
        REG_ROW_COUNT:    rows_reg = data[12:0];
        REG_START_OFFSET: start_off = data[4:0];
        REG_PITCH_REM:    pitch = data[4:0];
        REG_SWAPPED:      swap = data[0];
        default:          return;
      endcase
      rearm();
    endfunction

    function bit [31:0] lane_mask(int lo, int hi);
      bit [31:0] m;
      for (int i = 0; i < 32; i++) begin
        m[i] = swap ? (i >= 32 - hi && i < 32 - lo) : (i >= lo && i < hi);
      end
      return m;
    endfunction

    function void emit(bit [31:0] val, bit [31:0] m);
      word_t w;
      w.value       = val & m;
      w.mask        = m;
      w.row_end     = 1'b0;
      w.image_end   = 1'b0;
      w.last_of_run = 1'b0;
      pending.push_back(w);
    endfunction

    function void note_byte(bit [7:0] b);
      int        width;
      int        rows;
      int        n;
      bit [63:0] cmask;
      bit [31:0] color;
      bit [63:0] a;
      if (!depth_ok()) return;
      width = (width_reg == 0) ? 1 : width_reg;
      if (width > MAX_PIX) width = MAX_PIX;
      rows  = (rows_reg == 0) ? 1 : rows_reg;
      cmask = (64'd1 << bpp) - 64'd1;
      a     = swap ? {acc, 32'h0} : {32'h0, acc};
      n     = 0;
      for (int k = 0; k < 8 && pix < width; k++) begin
        color = (b[7 - k] ? fg : bg) & cmask[31:0];
        if (swap) a |= 64'(color) << (64 - fill - int'(bpp));
        else a |= 64'(color) << fill;
        fill += bpp;
        pix++;
        if (fill >= 32) begin
          emit(swap ? a[63:32] : a[31:0], lane_mask(first ? int'(row_off) : 0, 32));
          n++;
          a = swap ? (a << 32) : (a >> 32);
          fill -= 32;
          first = 1'b0;
        end
      end
      if (pix >= width) begin
        if (fill > 0) begin
          emit(swap ? a[63:32] : a[31:0], lane_mask(first ? int'(row_off) : 0, fill));
          n++;
        end
        if (n > 0) pending[pending.size() - 1].row_end = 1'b1;
        row++;
        if (row >= rows) begin
          if (n > 0) pending[pending.size() - 1].image_end = 1'b1;
          row     = 0;
          row_off = start_off;
        end else begin
          row_off = row_off + pitch;
        end
        a     = 64'h0;
        fill  = row_off;
        pix   = 0;
        first = 1'b1;
      end
      acc = swap ? a[63:32] : a[31:0];
      if (n > 0) pending[pending.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_word(logic [31:0] value, logic [31:0] mask, logic re, logic ie,
                             logic lr);
      word_t e;
      if (pending.size() == 0) begin
        $error("unexpected word: word_value %h word_mask %h", value, mask);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $error("word_value: expected %h, got %h", e.value, value);
        errors++;
      end
      if (mask !== e.mask) begin
        $error("word_mask: expected %h, got %h", e.mask, mask);
        errors++;
      end
      if (re !== e.row_end) begin
        $error("row_end: expected %b, got %b", e.row_end, re);
        errors++;
      end
      if (ie !== e.image_end) begin
        $error("image_end: expected %b, got %b", e.image_end, ie);
        errors++;
      end
      if (lr !== e.last_of_run) begin
        $error("last_of_run: expected %b, got %b", e.last_of_run, lr);
        errors++;
      end
    endfunction
  endclass

  blit_scoreboard sb;
  bit             in_calm;
  int             cycles;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_mono_bitmap_expand_blit: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_word(out_word_value, out_word_mask, out_row_end, out_image_end,
                      out_last_of_run);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_byte(in_bitmap_byte);
    end
  end

  initial begin
    int hold;
    int r;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r    = $urandom_range(0, 9);
      hold = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      r = $urandom_range(0, 9);
      repeat ((r < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60)) @(posedge clk);
    end
  end

  function automatic int input_gap();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic bit [31:0] pick_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hffff_ffff;
    return $urandom();
  endfunction

  function automatic bit [7:0] random_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic setup_t random_setup();
    setup_t s;
    int     r;
    r     = $urandom_range(0, 9);
    s.bpp = (r == 0) ? 6'($urandom()) : 6'(1 << $urandom_range(0, 5));
    s.fg  = pick_color();
    s.bg  = pick_color();
    r     = $urandom_range(0, 9);
    s.width = (r == 0) ? 13'd0 : (r < 8) ? 13'($urandom_range(1, 40))
                                         : 13'($urandom_range(41, 200));
    r      = $urandom_range(0, 9);
    s.rows = (r == 0) ? 13'd0 : (r == 1) ? 13'd4096 : 13'($urandom_range(1, 5));
    s.start = 5'($urandom());
    s.pitch = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 24))
                                         : 5'($urandom_range(25, 31));
    s.swap  = 1'($urandom());
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_bitmap_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_reg(input logic [3:0] idx, input logic [31:0] val, input int w);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (32'($urandom()) << w) | val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic put_field(input setup_t s, input logic [3:0] idx);
    case (idx)
      REG_PIXEL_BITS:   put_reg(idx, 32'(s.bpp), 6);
      REG_FORE_COLOR:   put_reg(idx, s.fg, 32);
      REG_BACK_COLOR:   put_reg(idx, s.bg, 32);
      REG_ROW_WIDTH:    put_reg(idx, 32'(s.width), 13);
      REG_ROW_COUNT:    put_reg(idx, 32'(s.rows), 13);
      REG_START_OFFSET: put_reg(idx, 32'(s.start), 5);
      REG_PITCH_REM:    put_reg(idx, 32'(s.pitch), 5);
      default:          put_reg(idx, 32'(s.swap), 1);
    endcase
  endtask

  task automatic load_setup(input setup_t s);
    for (int i = 0; i < NUM_REGS; i++) put_field(s, 4'(i));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    setup_t cur;
    setup_t nxt;
    int     done;
    int     r;
    int     n;
    sb      = new();
    in_calm = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'ha5);
    settle();

    // one-bit pixels from the last bit of a word, padded row, pitch past 24
    cur = '{bpp: 6'd1, fg: 32'hffff_ffff, bg: 32'h0, width: 13'd5, rows: 13'd2,
            start: 5'd31, pitch: 5'd31, swap: 1'b0};
    load_setup(cur);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h5a);
    settle();

    cur = '{bpp: 6'd32, fg: 32'h0, bg: 32'hffff_ffff, width: 13'd8, rows: 13'd0,
            start: 5'd7, pitch: 5'd24, swap: 1'b1};
    load_setup(cur);
    send_byte(8'h80);
    settle();
    cur.width = 13'd0;
    put_field(cur, REG_ROW_WIDTH);
    cfg_valid <= 1'b0;
    send_byte(8'h7f);
    settle();

    cur = '{bpp: 6'd16, fg: 32'h1234_abcd, bg: 32'hfedc_5678, width: 13'd12, rows: 13'd3,
            start: 5'd16, pitch: 5'd24, swap: 1'b1};
    load_setup(cur);
    send_byte(8'hc3);
    send_byte(8'h3c);
    send_byte(8'h99);
    settle();

    cur = '{bpp: 6'd2, fg: 32'h0000_000a, bg: 32'h0000_0005, width: 13'd13, rows: 13'd2,
            start: 5'd3, pitch: 5'd10, swap: 1'b0};
    load_setup(cur);
    send_byte(8'h81);
    send_byte(8'h7e);
    send_byte(8'he7);
    settle();

    cur = '{bpp: 6'd4, fg: 32'hdead_beef, bg: 32'h0bad_f00d, width: 13'd3, rows: 13'd1,
            start: 5'd30, pitch: 5'd0, swap: 1'b1};
    load_setup(cur);
    send_byte(8'hf0);
    send_byte(8'h0f);
    settle();

    // unsupported depths drop the byte
    cur.bpp = 6'd3;
    load_setup(cur);
    send_byte(8'hff);
    send_byte(8'h00);
    settle();
    cur.bpp = 6'd0;
    put_field(cur, REG_PIXEL_BITS);
    cfg_valid <= 1'b0;
    send_byte(8'h55);
    settle();
    cur.bpp = 6'd63;
    put_field(cur, REG_PIXEL_BITS);
    cfg_valid <= 1'b0;
    send_byte(8'haa);
    settle();

    cur = '{bpp: 6'd32, fg: 32'h8000_0001, bg: 32'h7fff_fffe, width: 13'd4096,
            rows: 13'd4096, start: 5'd0, pitch: 5'd0, swap: 1'b0};
    load_setup(cur);
    send_byte(8'ha5);
    send_byte(8'h5a);
    settle();

    done = 0;
    while (done < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        cur = random_setup();
        load_setup(cur);
      end else if (r < 8) begin
        nxt = random_setup();
        put_field(nxt, 4'($urandom_range(0, NUM_REGS - 1)));
        cfg_valid <= 1'b0;
      end else begin
        put_reg(4'($urandom_range(NUM_REGS, REG_LAST_CODE)), $urandom(), 32);
        cfg_valid <= 1'b0;
      end
      in_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 40);
      repeat (n) begin
        send_byte(random_byte());
        if (sb.depth_ok()) done++;
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("tb_mono_bitmap_expand_blit: clean");
    end else begin
      $display("tb_mono_bitmap_expand_blit: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mbeb_pkg.sv
rtl/mbeb_front.sv
rtl/mbeb_queue.sv
rtl/mbeb_back.sv
rtl/mono_bitmap_expand_blit.sv
rtl/mbeb_check.sv
tb/sv/tb_mono_bitmap_expand_blit.sv
